@@ sv/d2d_pkg.sv @@
// Shared constants, stage payload types and the month-start table for the
// day-number-to-date converter. Used by every module under sv/.
// No dependencies.
package d2d_pkg;

    localparam int unsigned CountW     = 22;
    localparam int unsigned DayW       = 23;
    localparam int unsigned YearW      = 14;
    localparam int unsigned MonthW     = 4;
    localparam int unsigned MdayW      = 5;
    localparam int unsigned WeekdayW   = 3;

    localparam int unsigned UnixOffset = 719162;
    localparam int unsigned LastDay    = 3652058;
    localparam int unsigned Days400    = 400 * 365 + 97;
    localparam int unsigned Days100    = 100 * 365 + 24;
    localparam int unsigned Days4      = 4 * 365 + 1;
    localparam int unsigned Days1      = 365;
    localparam int unsigned Years400   = 400;
    localparam int unsigned Years100   = 100;
    localparam int unsigned Years4     = 4;

    // Reciprocals for the two wide constant divisions: floor(2^shift / divisor).
    localparam int unsigned Recip400   = 29398;
    localparam int unsigned Shift400   = 32;
    localparam int unsigned Recip4     = 1435;
    localparam int unsigned Shift4     = 21;

    // Index of the last 4-year cycle in a century, and of the last century.
    localparam int unsigned LastCycle4 = 24;
    localparam int unsigned LastCent   = 3;
    localparam int unsigned LastYear4  = 3;

    // Day of year (from 0) of Feb 29, and the date fields it decodes to.
    localparam int unsigned LeapDayDoy = 59;
    localparam int unsigned FebMonth   = 2;
    localparam int unsigned FebLastDay = 29;

    typedef struct packed {
        logic [17:0]         rem;
        logic [4:0]          q400;
        logic [WeekdayW-1:0] weekday;
        logic                oor;
    } t_split;

    typedef struct packed {
        logic [YearW-1:0]    year;
        logic [8:0]          doy;
        logic                leap;
        logic [WeekdayW-1:0] weekday;
        logic                oor;
    } t_yday;

    typedef struct packed {
        logic [YearW-1:0]    year;
        logic [MonthW-1:0]   month;
        logic [MdayW-1:0]    mday;
        logic [WeekdayW-1:0] weekday;
        logic                oor;
    } t_date;

    // Days before the start of each month (0 = January) in a common year.
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/d2d_split.sv @@
// Front pipeline: epoch offset, range check, division by the 400-year cycle
// and the weekday (count modulo 7). Four register stages.
// Depends on d2d_pkg.
module d2d_split import d2d_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CountW-1:0] i_day_count,
    input  logic              i_from_unix_epoch,
    output logic              o_valid,
    input  logic              i_ready,
    output t_split            o_data
);

    logic [3:0] r_valid;
    logic [3:0] adv;

    // A stage moves when it is empty or the stage after it moves.
    always_comb begin
        adv[3] = !r_valid[3] || i_ready;
        adv[2] = !r_valid[2] || adv[3];
        adv[1] = !r_valid[1] || adv[2];
        adv[0] = !r_valid[0] || adv[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (adv[0]) r_valid[0] <= i_valid;
            if (adv[1]) r_valid[1] <= r_valid[0];
            if (adv[2]) r_valid[2] <= r_valid[1];
            if (adv[3]) r_valid[3] <= r_valid[2];
        end
    end

    // Stage 0: add the epoch offset and check the range.
    logic [DayW-1:0] n0_d, r0_d;
    logic            n0_oor, r0_oor;

    always_comb begin
        n0_d   = {1'b0, i_day_count}
               + (i_from_unix_epoch ? DayW'(UnixOffset) : DayW'(0));
        n0_oor = n0_d > DayW'(LastDay);
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_d   <= n0_d;
            r0_oor <= n0_oor;
        end
    end

    // Stage 1: quotient estimate by reciprocal, and the sum of octal digits
    // (eight is one modulo seven, so the digit sum keeps the residue).
    logic [37:0]     prod1;
    logic [4:0]      n1_qe, r1_qe;
    logic [5:0]      n1_sum, r1_sum;
    logic [DayW-1:0] r1_d;
    logic            r1_oor;

    always_comb begin
        prod1  = 38'(r0_d) * 38'(Recip400);
        n1_qe  = prod1[Shift400+4:Shift400];
        n1_sum = 6'(r0_d[2:0])   + 6'(r0_d[5:3])   + 6'(r0_d[8:6])   + 6'(r0_d[11:9])
               + 6'(r0_d[14:12]) + 6'(r0_d[17:15]) + 6'(r0_d[20:18]) + 6'(r0_d[22:21]);
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_d   <= r0_d;
            r1_qe  <= n1_qe;
            r1_sum <= n1_sum;
            r1_oor <= r0_oor;
        end
    end

    // Stage 2: remainder for the estimate, which may still be one short.
    logic [DayW-1:0]     prod2, diff2;
    logic [3:0]          fold2;
    logic [18:0]         n2_rem, r2_rem;
    logic [WeekdayW-1:0] n2_wd, r2_wd;
    logic [4:0]          r2_qe;
    logic                r2_oor;

    always_comb begin
        prod2  = DayW'(r1_qe) * DayW'(Days400);
        diff2  = r1_d - prod2;
        n2_rem = diff2[18:0];
        fold2  = 4'(r1_sum[5:3]) + 4'(r1_sum[2:0]);
        if (fold2 >= 4'd14) begin
            n2_wd = 3'(fold2 - 4'd14);
        end else if (fold2 >= 4'd7) begin
            n2_wd = 3'(fold2 - 4'd7);
        end else begin
            n2_wd = fold2[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_rem <= n2_rem;
            r2_qe  <= r1_qe;
            r2_wd  <= n2_wd;
            r2_oor <= r1_oor;
        end
    end

    // Stage 3: correct the estimate by one where the remainder is too large.
    t_split n3_data, r3_data;

    always_comb begin
        n3_data.weekday = r2_wd;
        n3_data.oor     = r2_oor;
        if (r2_rem >= 19'(Days400)) begin
            n3_data.rem  = 18'(r2_rem - 19'(Days400));
            n3_data.q400 = r2_qe + 5'd1;
        end else begin
            n3_data.rem  = r2_rem[17:0];
            n3_data.q400 = r2_qe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r3_data <= n3_data;
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_valid[3];
    assign o_data  = r3_data;

endmodule

@@ sv/d2d_cycles.sv @@
// Middle pipeline: splits the day within a 400-year cycle into centuries,
// 4-year cycles and years, builds the year and the leap flag. Five stages.
// Depends on d2d_pkg.
module d2d_cycles import d2d_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_split i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_yday  o_data
);

    logic [4:0] r_valid;
    logic [4:0] adv;

    always_comb begin
        adv[4] = !r_valid[4] || i_ready;
        adv[3] = !r_valid[3] || adv[4];
        adv[2] = !r_valid[2] || adv[3];
        adv[1] = !r_valid[1] || adv[2];
        adv[0] = !r_valid[0] || adv[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (adv[0]) r_valid[0] <= i_valid;
            if (adv[1]) r_valid[1] <= r_valid[0];
            if (adv[2]) r_valid[2] <= r_valid[1];
            if (adv[3]) r_valid[3] <= r_valid[2];
            if (adv[4]) r_valid[4] <= r_valid[3];
        end
    end

    // Stage 0: centuries by compare; the last day of the cycle lands in the
    // last century (index 3), which is the clamp the calendar needs.
    logic [1:0]          n0_q100, r0_q100;
    logic [15:0]         n0_r1, r0_r1;
    logic [YearW-1:0]    n0_year, r0_year;
    logic [WeekdayW-1:0] r0_wd;
    logic                r0_oor;

    always_comb begin
        if (i_data.rem >= 18'(3 * Days100)) begin
            n0_q100 = 2'd3;
        end else if (i_data.rem >= 18'(2 * Days100)) begin
            n0_q100 = 2'd2;
        end else if (i_data.rem >= 18'(Days100)) begin
            n0_q100 = 2'd1;
        end else begin
            n0_q100 = 2'd0;
        end
        n0_r1   = 16'(i_data.rem - 18'(32'(n0_q100) * Days100));
        n0_year = YearW'(32'(i_data.q400) * Years400);
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_q100 <= n0_q100;
            r0_r1   <= n0_r1;
            r0_year <= n0_year;
            r0_wd   <= i_data.weekday;
            r0_oor  <= i_data.oor;
        end
    end

    // Stage 1: 4-year cycle estimate by reciprocal.
    logic [26:0]         prod1;
    logic [4:0]          n1_qe, r1_qe;
    logic [YearW-1:0]    n1_year, r1_year;
    logic [15:0]         r1_r1;
    logic [1:0]          r1_q100;
    logic [WeekdayW-1:0] r1_wd;
    logic                r1_oor;

    always_comb begin
        prod1   = 27'(r0_r1) * 27'(Recip4);
        n1_qe   = prod1[Shift4+4:Shift4];
        n1_year = r0_year + YearW'(32'(r0_q100) * Years100);
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_qe   <= n1_qe;
            r1_year <= n1_year;
            r1_r1   <= r0_r1;
            r1_q100 <= r0_q100;
            r1_wd   <= r0_wd;
            r1_oor  <= r0_oor;
        end
    end

    // Stage 2: remainder for the estimate.
    logic [15:0]         diff2;
    logic [11:0]         n2_rem, r2_rem;
    logic [4:0]          r2_qe;
    logic [YearW-1:0]    r2_year;
    logic [1:0]          r2_q100;
    logic [WeekdayW-1:0] r2_wd;
    logic                r2_oor;

    always_comb begin
        diff2  = r1_r1 - 16'(32'(r1_qe) * Days4);
        n2_rem = diff2[11:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_rem  <= n2_rem;
            r2_qe   <= r1_qe;
            r2_year <= r1_year;
            r2_q100 <= r1_q100;
            r2_wd   <= r1_wd;
            r2_oor  <= r1_oor;
        end
    end

    // Stage 3: correct the 4-year quotient.
    logic [10:0]         n3_r2, r3_r2;
    logic [4:0]          n3_q4, r3_q4;
    logic [YearW-1:0]    r3_year;
    logic [1:0]          r3_q100;
    logic [WeekdayW-1:0] r3_wd;
    logic                r3_oor;

    always_comb begin
        if (r2_rem >= 12'(Days4)) begin
            n3_r2 = 11'(r2_rem - 12'(Days4));
            n3_q4 = r2_qe + 5'd1;
        end else begin
            n3_r2 = r2_rem[10:0];
            n3_q4 = r2_qe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r3_r2   <= n3_r2;
            r3_q4   <= n3_q4;
            r3_year <= r2_year;
            r3_q100 <= r2_q100;
            r3_wd   <= r2_wd;
            r3_oor  <= r2_oor;
        end
    end

    // Stage 4: years by compare, clamped so Dec 31 of a leap year stays in it.
    // A year is leap when it ends a 4-year cycle, unless that cycle ends a
    // century that does not also end the 400-year cycle.
    logic [1:0] q1;
    t_yday      n4_data, r4_data;

    always_comb begin
        if (r3_r2 >= 11'(3 * Days1)) begin
            q1 = 2'd3;
        end else if (r3_r2 >= 11'(2 * Days1)) begin
            q1 = 2'd2;
        end else if (r3_r2 >= 11'(Days1)) begin
            q1 = 2'd1;
        end else begin
            q1 = 2'd0;
        end
        n4_data.doy     = 9'(r3_r2 - 11'(32'(q1) * Days1));
        n4_data.leap    = (q1 == 2'(LastYear4))
                       && ((r3_q4 != 5'(LastCycle4)) || (r3_q100 == 2'(LastCent)));
        n4_data.year    = r3_year + YearW'(32'(r3_q4) * Years4) + YearW'(q1) + YearW'(1);
        n4_data.weekday = r3_wd;
        n4_data.oor     = r3_oor;
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r4_data <= n4_data;
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_valid[4];
    assign o_data  = r4_data;

endmodule

@@ sv/d2d_month.sv @@
// Back pipeline: turns the day of the year into month and day of month with
// the month-start table, and blanks results that are out of range. Two stages.
// Depends on d2d_pkg.
module d2d_month import d2d_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_yday i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_date o_data
);

    logic [1:0] r_valid;
    logic [1:0] adv;

    always_comb begin
        adv[1] = !r_valid[1] || i_ready;
        adv[0] = !r_valid[0] || adv[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (adv[0]) r_valid[0] <= i_valid;
            if (adv[1]) r_valid[1] <= r_valid[0];
        end
    end

    // Stage 0: in a leap year, days after Feb 29 shift back by one so the
    // common-year table applies; Feb 29 itself is flagged.
    logic [8:0]          n0_adj, r0_adj;
    logic                n0_feb29, r0_feb29;
    logic [YearW-1:0]    r0_year;
    logic [WeekdayW-1:0] r0_wd;
    logic                r0_oor;

    always_comb begin
        n0_feb29 = i_data.leap && (i_data.doy == 9'(LeapDayDoy));
        if (i_data.leap && (i_data.doy > 9'(LeapDayDoy))) begin
            n0_adj = i_data.doy - 9'd1;
        end else begin
            n0_adj = i_data.doy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_adj   <= n0_adj;
            r0_feb29 <= n0_feb29;
            r0_year  <= i_data.year;
            r0_wd    <= i_data.weekday;
            r0_oor   <= i_data.oor;
        end
    end

    // Stage 1: month lookup against the eleven month starts, then the day.
    logic [3:0] midx;
    t_date      n1_data, r1_data;

    always_comb begin
        midx = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (r0_adj >= month_start(4'(k))) begin
                midx = 4'(k);
            end
        end
        n1_data.year    = r0_year;
        n1_data.weekday = r0_wd;
        n1_data.oor     = r0_oor;
        if (r0_feb29) begin
            n1_data.month = MonthW'(FebMonth);
            n1_data.mday  = MdayW'(FebLastDay);
        end else begin
            n1_data.month = midx + 4'd1;
            n1_data.mday  = 5'(r0_adj - month_start(midx) + 9'd1);
        end
        if (r0_oor) begin
            n1_data.year    = '0;
            n1_data.month   = '0;
            n1_data.mday    = '0;
            n1_data.weekday = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_data <= n1_data;
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_valid[1];
    assign o_data  = r1_data;

endmodule

@@ sv/day_number_to_date.sv @@
// Day number to Gregorian date converter, top level.
// Depends on d2d_pkg, d2d_split, d2d_cycles and d2d_month.
//
// A request on the slave channel carries a day count in tdata and, in tuser,
// a flag that moves the origin from 0001-01-01 to 1970-01-01. Each request
// yields exactly one result on the master channel: year, month, day of month
// and weekday (Monday = 0) in tdata, and in tuser a range flag that is set
// when the count lies past 9999-12-31, with all date fields then zero.
//
// The datapath is an eleven-stage pipeline: four stages for the offset, the
// 400-year division and the weekday, five for the century, 4-year and year
// split, two for the month lookup. One request is taken in every cycle unless
// a stall has filled all stages, bounded by the reciprocal multiply and
// correct steps that each take their own stage. Every stage holds a valid
// bit, and a stage moves whenever it is empty or the stage after it moves, so
// bubbles close up while the receiver stalls and o_s_tready falls only when
// all eleven stages hold results. A stall never drops or repeats a result.
// Reset clears the valid bits; the pipeline is empty and ready in the first
// cycle after it.
module day_number_to_date import d2d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [21:0] day_count, [23:22] zero
    input  logic [0:0]  i_s_tuser,   // [0] from_unix_epoch
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [13:0] year, [17:14] month,
                                     // [22:18] day_of_month, [25:23] weekday,
                                     // [31:26] zero
    output logic [0:0]  o_m_tuser    // [0] out_of_range
);

    logic   split_valid, split_ready;
    t_split split_data;
    logic   yday_valid, yday_ready;
    t_yday  yday_data;
    t_date  date;

    d2d_split u_split (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_s_tvalid),
        .o_ready           (o_s_tready),
        .i_day_count       (i_s_tdata[CountW-1:0]),
        .i_from_unix_epoch (i_s_tuser[0]),
        .o_valid           (split_valid),
        .i_ready           (split_ready),
        .o_data            (split_data)
    );

    d2d_cycles u_cycles (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_valid),
        .o_ready (split_ready),
        .i_data  (split_data),
        .o_valid (yday_valid),
        .i_ready (yday_ready),
        .o_data  (yday_data)
    );

    d2d_month u_month (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (yday_valid),
        .o_ready (yday_ready),
        .i_data  (yday_data),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (date)
    );

    assign o_m_tdata = {6'd0, date.weekday, date.mday, date.month, date.year};
    assign o_m_tuser = date.oor;

`ifndef SYNTH
    // An out-of-range result carries an all-zero date.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == 32'd0))
        else $error("out-of-range result with nonzero date fields");

    // An in-range result is a well-formed date.
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |->
            (o_m_tdata[13:0] != 14'd0) && (o_m_tdata[17:14] != 4'd0)
            && (o_m_tdata[17:14] <= 4'd12) && (o_m_tdata[22:18] != 5'd0)
            && (o_m_tdata[25:23] <= 3'd6))
        else $error("in-range result with an invalid date field");

    // With the output register empty every stage can move.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while the output is empty");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule
